@@ src/lzwc_pkg.sv @@
// Shared constants and types for the LZW compressor
`default_nettype none
package lzwc_pkg;
   localparam int TableSizeDefault = 9973;
   localparam int MaxInputDefault  = 8192;
   localparam int HashShiftDefault = 5;
   localparam int CodeW = 14;
   localparam int CountW = 14;
   localparam int EpochW = 8;
   localparam logic [CodeW-1:0] CodeEnd   = 14'd256;
   localparam logic [CodeW-1:0] CodeGrow  = 14'd257;
   localparam logic [CodeW-1:0] FirstFree = 14'd258;
   localparam logic [3:0] StartWidth = 4'd9;
   localparam logic [14:0] StartBump = 15'd512;
   localparam logic [13:0] LimitReset = 14'd8192;
   localparam logic [2:0] StOk = 3'd0;
   localparam logic [2:0] StOverflow = 3'd1;
   localparam logic [2:0] StNoGain = 3'd2;
   localparam logic [2:0] StTooLong = 3'd3;
   localparam logic [2:0] StFull = 3'd4;
   // datapath commands
   localparam logic [3:0] CmdNone = 4'd0;
   localparam logic [3:0] CmdStart = 4'd1;   // load byte, count it, clear staging
   localparam logic [3:0] CmdHash = 4'd2;    // compute first probe index
   localparam logic [3:0] CmdRead = 4'd3;    // issue memory read at index
   localparam logic [3:0] CmdInsert = 4'd4;  // write entry, queue prefix code
   localparam logic [3:0] CmdMatch = 4'd5;   // follow matching entry
   localparam logic [3:0] CmdStep = 4'd6;    // advance probe index
   localparam logic [3:0] CmdPutPrefix = 4'd7;
   localparam logic [3:0] CmdPutEnd = 4'd8;
   localparam logic [3:0] CmdPutGrow = 4'd9;
   localparam logic [3:0] CmdFlush = 4'd10;
   localparam logic [3:0] CmdClear = 4'd11;  // sweep one table row
   localparam logic [3:0] CmdFirst = 4'd12;  // first byte becomes prefix
   localparam logic [3:0] CmdSend = 4'd13;   // move one staged byte to the output
   typedef struct packed {
      logic [3:0] op;
      logic       emit_bit;   // shift one bit of the queued code
      logic       new_msg;    // reset message counters
   } dp_cmd_type;
   typedef struct packed {
      logic hit_valid;
      logic hit_match;
      logic bump;        // next free code reached bump point
      logic bits_left;   // queued code has bits remaining
      logic byte_ready;  // a packed byte waits in the output slot
      logic overflow;
      logic too_long;
      logic no_gain;
      logic probes_out;
      logic first;
      logic pend_any;
      logic clear_done;
      logic out_busy;
      logic stage_more;  // staged bytes not yet sent
   } dp_sts_type;
endpackage
`default_nettype wire

@@ src/lzwc_datapath.sv @@
// Datapath: hash table memory, code state, bit packer and output register
`default_nettype none
module lzwc_datapath import lzwc_pkg::*; #(
   parameter int TableSize = TableSizeDefault,
   parameter int MaxInput = MaxInputDefault,
   parameter int HashShift = HashShiftDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   input  wire logic [7:0] in_byte,
   input  wire logic [13:0] limit,
   input  wire logic       err_send,
   input  wire logic [2:0] err_code,
   input  wire logic       last_flag,
   output dp_sts_type      sts,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output logic [2:0]      rsp_status
);
   localparam int IdxW = $clog2(TableSize);
   localparam int HashW = (8 + HashShift > CodeW) ? 8 + HashShift : CodeW;
   localparam int RowW = EpochW + CodeW + CodeW + 8;

   // table: row holds epoch tag, code, prefix, char
   logic [RowW-1:0] mem_data [TableSize];
   logic [RowW-1:0] rd_ff;
   logic [EpochW-1:0] epoch_ff;
   logic [IdxW-1:0] clr_ff;
   logic clr_on_ff;
   logic [IdxW-1:0] idx_ff, idx_in, step_ff;
   logic [IdxW+1:0] probes_ff;
   logic [CodeW-1:0] prefix_ff, free_ff;
   logic [3:0] width_ff;
   logic [14:0] bump_ff;
   logic [7:0] ch_ff, pbits_ff;
   logic [2:0] pcnt_ff;
   logic [CountW:0] bin_ff, bout_ff;
   logic first_ff;
   logic [CodeW-1:0] q_code_ff;
   logic [3:0] q_left_ff;
   logic [HashW-1:0] hash_raw;
   logic [IdxW-1:0] hash_idx;
   logic [7:0] ob_ff;
   logic ol_ff, ov_ff;
   logic [2:0] os_ff;
   logic [7:0] stg_ff [8];
   logic [3:0] stg_cnt_ff, stg_rd_ff;
   logic [7:0] stage_in;

   // reduce hash modulo table size by subtracting shifted multiples
   always_comb begin
      logic [HashW:0] v;
      hash_raw = HashW'({ch_ff, HashShift'(0)}) ^ HashW'(prefix_ff);
      v = {1'b0, hash_raw};
      for (int k = HashW - IdxW; k >= 0; k--)
         if (v >= (HashW+1)'(TableSize << k)) v = v - (HashW+1)'(TableSize << k);
      hash_idx = IdxW'(v);
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.op == CmdHash) idx_in = hash_idx;
      else if (cmd.op == CmdStep)
         idx_in = (idx_ff >= step_ff) ? idx_ff - step_ff
                  : IdxW'(idx_ff + IdxW'(TableSize) - step_ff);
   end

   // table memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.op == CmdClear) mem_data[clr_ff] <= '0;
      else if (cmd.op == CmdInsert)
         mem_data[idx_ff] <= {epoch_ff, free_ff, prefix_ff, ch_ff};
      rd_ff <= mem_data[idx_ff];
   end

   // advance the epoch per message; sweep the table after reset and on wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EpochW'(1); clr_ff <= '0; clr_on_ff <= 1'b1;
      end else if (cmd.new_msg) begin
         if (epoch_ff == '1) begin
            epoch_ff <= EpochW'(1); clr_ff <= '0; clr_on_ff <= 1'b1;
         end else epoch_ff <= epoch_ff + 1'b1;
      end else if (cmd.op == CmdClear) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == IdxW'(TableSize - 1)) clr_on_ff <= 1'b0;
      end
   end

   logic packing, out_take;
   assign out_take = rsp_valid && rsp_ready;
   assign packing = cmd.emit_bit;

   // code state and packer
   always_ff @(posedge clock) begin
      if (reset || cmd.new_msg) begin
         prefix_ff <= '0; free_ff <= FirstFree; width_ff <= StartWidth;
         bump_ff <= StartBump; pbits_ff <= '0; pcnt_ff <= '0;
         bin_ff <= '0; bout_ff <= '0; first_ff <= 1'b1; q_left_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         unique case (cmd.op)
            CmdStart: begin ch_ff <= in_byte; bin_ff <= bin_ff + 1'b1; end
            CmdFirst: begin prefix_ff <= CodeW'(ch_ff); first_ff <= 1'b0; end
            CmdHash: begin
               step_ff <= (hash_idx == '0) ? IdxW'(1) : IdxW'(IdxW'(TableSize) - hash_idx);
               probes_ff <= '0;
            end
            CmdStep: probes_ff <= probes_ff + 1'b1;
            CmdInsert: begin
               q_code_ff <= prefix_ff; q_left_ff <= width_ff;
               free_ff <= free_ff + 1'b1; prefix_ff <= CodeW'(ch_ff);
            end
            CmdMatch: prefix_ff <= rd_ff[CodeW+CodeW+7:CodeW+8];
            CmdPutPrefix: begin q_code_ff <= prefix_ff; q_left_ff <= width_ff; end
            CmdPutEnd: begin q_code_ff <= CodeEnd; q_left_ff <= width_ff; end
            CmdPutGrow: begin
               q_code_ff <= CodeGrow; q_left_ff <= width_ff;
               width_ff <= width_ff + 1'b1; bump_ff <= {bump_ff[13:0], 1'b0};
            end
            CmdFlush: begin
               pbits_ff <= pbits_ff << (4'd8 - {1'b0, pcnt_ff}); pcnt_ff <= 3'd0;
            end
            default: ;
         endcase
         if (packing) begin
            if (pcnt_ff == 3'd0) bout_ff <= bout_ff + 1'b1;
            pbits_ff <= {pbits_ff[6:0], q_code_ff[q_left_ff-1'b1]};
            pcnt_ff <= pcnt_ff + 1'b1;
            q_left_ff <= q_left_ff - 1'b1;
         end
      end
   end

   assign stage_in = (cmd.op == CmdFlush) ? 8'(pbits_ff << (4'd8 - {1'b0, pcnt_ff}))
                     : {pbits_ff[6:0], q_code_ff[q_left_ff-1'b1]};

   // stage the packed bytes of one input byte until it ends without error
   always_ff @(posedge clock) begin
      if (reset || cmd.op == CmdStart) begin
         stg_cnt_ff <= '0; stg_rd_ff <= '0;
      end else begin
         if ((packing && pcnt_ff == 3'd7) || cmd.op == CmdFlush) begin
            stg_ff[stg_cnt_ff[2:0]] <= stage_in;
            stg_cnt_ff <= stg_cnt_ff + 1'b1;
         end
         if (cmd.op == CmdSend) stg_rd_ff <= stg_rd_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (err_send) begin
         ov_ff <= 1'b1; ob_ff <= '0; ol_ff <= 1'b1; os_ff <= err_code;
      end else if (cmd.op == CmdSend) begin
         ov_ff <= 1'b1; os_ff <= StOk; ob_ff <= stg_ff[stg_rd_ff[2:0]];
         ol_ff <= last_flag && (stg_rd_ff + 1'b1 == stg_cnt_ff);
      end else if (out_take) ov_ff <= 1'b0;
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_out_last = ol_ff;
   assign rsp_status = os_ff;

   assign sts.hit_valid = rd_ff[RowW-1 -: EpochW] == epoch_ff;
   assign sts.hit_match = rd_ff[CodeW+7:8] == prefix_ff && rd_ff[7:0] == ch_ff;
   assign sts.bump = {1'b0, free_ff} >= bump_ff;
   assign sts.bits_left = q_left_ff != 4'd0;
   assign sts.byte_ready = ov_ff;
   assign sts.overflow = pcnt_ff == 3'd0 && bout_ff >= {1'b0, limit};
   assign sts.too_long = bin_ff >= (CountW+1)'(MaxInput);
   assign sts.no_gain = bout_ff >= bin_ff;
   assign sts.probes_out = probes_ff >= (IdxW+2)'(TableSize + 1);
   assign sts.first = first_ff;
   assign sts.pend_any = pcnt_ff != 3'd0;
   assign sts.clear_done = !clr_on_ff;
   assign sts.out_busy = ov_ff && !rsp_ready;
   assign sts.stage_more = stg_rd_ff != stg_cnt_ff;
endmodule
`default_nettype wire

@@ src/lzwc_control.sv @@
// Controller state machine sequencing one byte through probe and packing
`default_nettype none
module lzwc_control import lzwc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_in_last,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd,
   output logic            err_send,
   output logic [2:0]      err_code,
   output logic            last_flag
);
   localparam logic [3:0] SIdle = 4'd0, SDecide = 4'd1, SHash = 4'd2, SRead = 4'd3,
      SWait = 4'd4, SLook = 4'd5, SPack = 4'd6, SAfter = 4'd7, SGrow = 4'd8,
      SEnd1 = 4'd9, SEnd2 = 4'd10, SFlush = 4'd11, SFinal = 4'd12, SErr = 4'd13;
   logic [3:0] st_ff, st_in, ret_ff, ret_in;
   logic last_ff, drop_ff, drop_in;
   logic [2:0] ec_ff, ec_in;

   assign last_flag = last_ff;
   assign err_code = ec_ff;

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; drop_in = drop_ff; ec_in = ec_ff;
      cmd = '{op: CmdNone, emit_bit: 1'b0, new_msg: 1'b0};
      err_send = 1'b0;
      req_ready = (st_ff == SIdle) && !sts.byte_ready && sts.clear_done;
      unique case (st_ff)
         SIdle: if (!sts.clear_done) cmd.op = CmdClear;
            else if (req_valid && req_ready) begin
               if (drop_ff) begin
                  if (req_in_last) begin drop_in = 1'b0; cmd.new_msg = 1'b1; end
               end else if (sts.too_long) begin
                  ec_in = StTooLong; st_in = SErr;
               end else begin
                  cmd.op = CmdStart; st_in = SDecide;
               end
            end
         SDecide: if (sts.first) begin
            cmd.op = CmdFirst; st_in = last_ff ? SEnd1 : SIdle;
         end else begin cmd.op = CmdHash; st_in = SRead; end
         SRead: begin cmd.op = CmdRead; st_in = SWait; end
         SWait: st_in = SLook;
         SLook: if (!sts.hit_valid) begin
            cmd.op = CmdInsert; ret_in = SAfter; st_in = SPack;
         end else if (sts.hit_match) begin
            cmd.op = CmdMatch; st_in = last_ff ? SEnd1 : SIdle;
         end else if (sts.probes_out) begin
            ec_in = StFull; st_in = SErr;
         end else begin cmd.op = CmdStep; st_in = SRead; end
         SPack: if (!sts.bits_left) st_in = ret_ff;
            else if (sts.overflow) begin ec_in = StOverflow; st_in = SErr; end
            else cmd.emit_bit = 1'b1;
         SAfter: st_in = sts.bump ? SGrow : (last_ff ? SEnd1 : SFinal);
         SGrow: begin cmd.op = CmdPutGrow; ret_in = last_ff ? SEnd1 : SFinal;
            st_in = SPack; end
         SEnd1: begin cmd.op = CmdPutPrefix; ret_in = SEnd2; st_in = SPack; end
         SEnd2: begin cmd.op = CmdPutEnd; ret_in = SFlush; st_in = SPack; end
         SFlush: if (sts.no_gain) begin ec_in = StNoGain; st_in = SErr; end
            else begin
               if (sts.pend_any) cmd.op = CmdFlush;
               st_in = SFinal;
            end
         // release the staged bytes one by one, then close the message if last
         SFinal: if (sts.stage_more) begin
               if (!sts.out_busy) cmd.op = CmdSend;
            end else begin
               if (last_ff) cmd.new_msg = 1'b1;
               st_in = SIdle;
            end
         SErr: if (!sts.out_busy) begin
            err_send = 1'b1; cmd.new_msg = 1'b1; st_in = SIdle;
            drop_in = !last_ff;
         end
         default: st_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SIdle; ret_ff <= SIdle; drop_ff <= 1'b0; ec_ff <= StOk; last_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; drop_ff <= drop_in; ec_ff <= ec_in;
         if (st_ff == SIdle && req_valid && req_ready) last_ff <= req_in_last;
      end
   end
endmodule
`default_nettype wire

@@ src/lzw_compressor_variable_width.sv @@
// Top level of the variable-width LZW compressor
// A byte that extends the current string is hashed, read and matched; each extra
// hash probe repeats the read. A new code is written and shifted out one bit per
// cycle, a width step adds another code, and packed bytes go out as the output frees.
// One byte at a time. Reset (synchronous, active high) restores output_limit to 8192
// and all message state, then sweeps the table; the sweep repeats every 255 messages.
`default_nettype none
module lzw_compressor_variable_width import lzwc_pkg::*; #(
   parameter int TableSize = TableSizeDefault,
   parameter int MaxInput = MaxInputDefault,
   parameter int HashShift = HashShiftDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_write,
   input  wire logic [13:0] csr_wdata
);
   logic [13:0] limit_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic err_send, last_flag;
   logic [2:0] err_code;

   // hold the output limit register
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LimitReset;
      else if (csr_write) limit_ff <= csr_wdata;
   end

   lzwc_control u_ctl (.clock, .reset, .req_valid, .req_ready, .req_in_last, .sts, .cmd,
      .err_send, .err_code, .last_flag);

   lzwc_datapath #(.TableSize(TableSize), .MaxInput(MaxInput), .HashShift(HashShift))
   u_dp (.clock, .reset, .cmd, .in_byte(req_in_byte), .limit(limit_ff), .err_send,
      .err_code, .last_flag, .sts, .rsp_valid, .rsp_ready, .rsp_out_byte,
      .rsp_out_last, .rsp_status);

   a_status_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StOk |-> rsp_out_last) else $error("error not last");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StOk |-> rsp_out_byte == 8'd0) else $error("err byte");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("accept while stalled");
endmodule
`default_nettype wire
